/* design/pths_pkg.sv */
// ----------------------------------------------------------------------------
// pths_pkg: shared types and constants of the pan/tilt homing sequencer
// Stage codes, register indexes, reset values and the structs that pass
// between the core and its step logic.
// ----------------------------------------------------------------------------
package pths_pkg;

  localparam int TIME_BITS = 32;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Stage codes
  localparam logic [3:0] ST_STOP           = 4'd0;
  localparam logic [3:0] ST_PAN_INIT       = 4'd1;
  localparam logic [3:0] ST_PAN_SEEK_STOP  = 4'd2;
  localparam logic [3:0] ST_PAN_SEEK_HALL  = 4'd3;
  localparam logic [3:0] ST_TILT_INIT      = 4'd4;
  localparam logic [3:0] ST_TILT_SEEK_HALL = 4'd5;
  localparam logic [3:0] ST_TILT_FINETUNE  = 4'd6;
  localparam logic [3:0] ST_FINISH         = 4'd7;
  localparam logic [3:0] ST_IDLE           = 4'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STALL_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_STOP_PWM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_HALL_PWM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_HALL_PWM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_FINE_PWM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FINETUNE_TIME  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_REPEAT   = 3'd6;

  // Register reset values
  localparam logic [15:0]       RST_STALL_PERIOD  = 16'd300;
  localparam logic signed [7:0] RST_PAN_STOP_PWM  = -8'sd40;
  localparam logic signed [7:0] RST_PAN_HALL_PWM  = 8'sd43;
  localparam logic signed [7:0] RST_TILT_HALL_PWM = -8'sd40;
  localparam logic signed [7:0] RST_TILT_FINE_PWM = 8'sd25;
  localparam logic [15:0]       RST_FINETUNE_TIME = 16'd1300;
  localparam logic [3:0]        RST_STALL_REPEAT  = 4'd4;

  typedef struct packed {
    logic [15:0]       stall_sample_period_ms;
    logic signed [7:0] pan_seek_stop_pwm;
    logic signed [7:0] pan_seek_hall_pwm;
    logic signed [7:0] tilt_seek_hall_pwm;
    logic signed [7:0] tilt_finetune_pwm;
    logic [15:0]       finetune_time_ms;
    logic [3:0]        stall_repeat_count;
  } cfg_t;

  typedef struct packed {
    logic [3:0]           stage;
    logic [TIME_BITS-1:0] mark_time;
    logic [15:0]          last_encoder;
    logic [3:0]           stall_count;
    logic                 slew_flag;
    logic                 bounds_flag;
    logic                 done_flag;
  } seq_state_t;

  typedef struct packed {
    logic                 restart;
    logic [TIME_BITS-1:0] now_ms;
    logic signed [15:0]   pan_encoder;
    logic signed [7:0]    tilt_pwm_now;
    logic signed [7:0]    pan_pwm_now;
    logic                 tilt_hall;
    logic                 pan_hall;
  } tick_t;

  typedef struct packed {
    logic              tilt_pwm_write;
    logic signed [7:0] tilt_pwm_cmd;
    logic              pan_pwm_write;
    logic signed [7:0] pan_pwm_cmd;
    logic              pan_encoder_taken;
    logic              slew_on;
    logic              bounds_on;
    logic              homed;
    logic [3:0]        stage_now;
    logic              finished;
  } result_t;

endpackage

/* design/pths_step.sv */
// ----------------------------------------------------------------------------
// pths_step: one control tick of the homing sequence
// Combinational next-state and command logic for a single tick.
// ----------------------------------------------------------------------------
module pths_step
  import pths_pkg::*;
(
  input  cfg_t       cfg,
  input  seq_state_t st,
  input  tick_t      tick,
  output seq_state_t st_nxt,
  output result_t    res
);

  logic [TIME_BITS-1:0] elapsed;
  logic [3:0]           stall_inc;
  logic [3:0]           stage_in;
  logic                 bounds_in;

  assign elapsed   = tick.now_ms - st.mark_time;
  assign stall_inc = st.stall_count + 4'd1;
  // restart forces the stop stage and drops bounds before the tick
  assign stage_in  = tick.restart ? ST_STOP : st.stage;
  assign bounds_in = tick.restart ? 1'b0 : st.bounds_flag;

  always_comb begin
    st_nxt             = st;
    st_nxt.bounds_flag = bounds_in;
    st_nxt.stage       = stage_in;
    res                = '0;

    case (stage_in)
      ST_STOP: begin
        res.tilt_pwm_write = 1'b1;
        res.pan_pwm_write  = 1'b1;
        if (tick.tilt_pwm_now == 8'sd0 && tick.pan_pwm_now == 8'sd0) begin
          st_nxt.done_flag    = 1'b0;
          st_nxt.last_encoder = '0;
          st_nxt.slew_flag    = 1'b0;
          st_nxt.bounds_flag  = 1'b0;
          st_nxt.stage        = ST_PAN_INIT;
        end
      end
      ST_PAN_INIT: begin
        res.pan_pwm_write     = 1'b1;
        res.pan_pwm_cmd       = cfg.pan_seek_stop_pwm;
        res.pan_encoder_taken = 1'b1;
        st_nxt.last_encoder   = tick.pan_encoder;
        st_nxt.stall_count    = '0;
        st_nxt.stage          = ST_PAN_SEEK_STOP;
      end
      ST_PAN_SEEK_STOP: begin
        if (elapsed >= {{(TIME_BITS-16){1'b0}}, cfg.stall_sample_period_ms}) begin
          st_nxt.mark_time      = tick.now_ms;
          res.pan_encoder_taken = 1'b1;
          if (tick.pan_encoder != st.last_encoder) begin
            st_nxt.last_encoder = tick.pan_encoder;
            st_nxt.stall_count  = '0;
          end else begin
            st_nxt.stall_count = stall_inc;
            if (stall_inc >= cfg.stall_repeat_count) begin
              res.pan_pwm_write = 1'b1;
              res.pan_pwm_cmd   = cfg.pan_seek_hall_pwm;
              st_nxt.stage      = ST_PAN_SEEK_HALL;
            end
          end
        end
      end
      ST_PAN_SEEK_HALL: begin
        if (tick.pan_hall) begin
          res.pan_pwm_write = 1'b1;
          st_nxt.stage      = ST_TILT_INIT;
        end
      end
      ST_TILT_INIT: begin
        res.tilt_pwm_write = 1'b1;
        res.tilt_pwm_cmd   = cfg.tilt_seek_hall_pwm;
        st_nxt.stage       = ST_TILT_SEEK_HALL;
      end
      ST_TILT_SEEK_HALL: begin
        if (tick.tilt_hall) begin
          st_nxt.slew_flag   = 1'b1;
          res.tilt_pwm_write = 1'b1;
          res.tilt_pwm_cmd   = cfg.tilt_finetune_pwm;
          st_nxt.mark_time   = tick.now_ms;
          st_nxt.stage       = ST_TILT_FINETUNE;
        end
      end
      ST_TILT_FINETUNE: begin
        if (elapsed >= {{(TIME_BITS-16){1'b0}}, cfg.finetune_time_ms}) begin
          st_nxt.slew_flag   = 1'b0;
          res.tilt_pwm_write = 1'b1;
          st_nxt.stage       = ST_FINISH;
        end
      end
      ST_FINISH: begin
        res.finished       = 1'b1;
        st_nxt.slew_flag   = 1'b1;
        st_nxt.bounds_flag = 1'b1;
        st_nxt.done_flag   = 1'b1;
        st_nxt.stage       = ST_IDLE;
      end
      default: begin
        st_nxt.stage = ST_IDLE;
      end
    endcase

    res.slew_on   = st_nxt.slew_flag;
    res.bounds_on = st_nxt.bounds_flag;
    res.homed     = st_nxt.done_flag;
    res.stage_now = st_nxt.stage;
  end

endmodule

/* design/pan_tilt_homing_sequencer_core.sv */
// ----------------------------------------------------------------------------
// pan_tilt_homing_sequencer_core: pan/tilt calibration sequencer
// Takes one control tick per transfer and returns one command/status
// transfer per tick.
// ----------------------------------------------------------------------------
// Path: the input register captures the tick at its transfer, and the step
//   logic feeds the result register from that held tick; the result
//   register then drives out_tvalid and out_tdata.
// Throughput: one tick per cycle while out_tready is high; the result
//   register frees the input side as soon as its result is taken.
// Reset (rst_n low, synchronous): stage idle, slew on, bounds and homed off,
//   timers and counters cleared, registers at their default values.
module pan_tilt_homing_sequencer_core
  import pths_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // tick input
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata, LSB up: restart[0], now_ms[32:1], pan_encoder[48:33],
  //   tilt_pwm_now[56:49], pan_pwm_now[64:57], tilt_hall[65], pan_hall[66]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result output
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata, LSB up: tilt_pwm_write[0], tilt_pwm_cmd[8:1], pan_pwm_write[9],
  //   pan_pwm_cmd[17:10], pan_encoder_taken[18], slew_on[19], bounds_on[20],
  //   homed[21], stage_now[25:22], finished[26]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cfg_t       cfg_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  tick_t      tick_r;
  tick_t      tick_in;
  result_t    res_nxt;
  result_t    res_r;
  logic       in_valid_r;
  logic       out_valid_r;
  logic       advance;

  // Unpack the incoming transfer
  assign tick_in.restart      = in_tdata[0];
  assign tick_in.now_ms       = in_tdata[32:1];
  assign tick_in.pan_encoder  = in_tdata[48:33];
  assign tick_in.tilt_pwm_now = in_tdata[56:49];
  assign tick_in.pan_pwm_now  = in_tdata[64:57];
  assign tick_in.tilt_hall    = in_tdata[65];
  assign tick_in.pan_hall     = in_tdata[66];

  // Move the held tick into the result register when that register is
  // empty or being drained this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Configuration registers: the user must write them only while the sequencer is quiet; the core does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stall_sample_period_ms <= RST_STALL_PERIOD;
      cfg_r.pan_seek_stop_pwm      <= RST_PAN_STOP_PWM;
      cfg_r.pan_seek_hall_pwm      <= RST_PAN_HALL_PWM;
      cfg_r.tilt_seek_hall_pwm     <= RST_TILT_HALL_PWM;
      cfg_r.tilt_finetune_pwm      <= RST_TILT_FINE_PWM;
      cfg_r.finetune_time_ms       <= RST_FINETUNE_TIME;
      cfg_r.stall_repeat_count     <= RST_STALL_REPEAT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STALL_PERIOD:  cfg_r.stall_sample_period_ms <= cfg_data;
        REG_PAN_STOP_PWM:  cfg_r.pan_seek_stop_pwm      <= cfg_data[7:0];
        REG_PAN_HALL_PWM:  cfg_r.pan_seek_hall_pwm      <= cfg_data[7:0];
        REG_TILT_HALL_PWM: cfg_r.tilt_seek_hall_pwm     <= cfg_data[7:0];
        REG_TILT_FINE_PWM: cfg_r.tilt_finetune_pwm      <= cfg_data[7:0];
        REG_FINETUNE_TIME: cfg_r.finetune_time_ms       <= cfg_data;
        REG_STALL_REPEAT:  cfg_r.stall_repeat_count     <= cfg_data[3:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Input register: hold the tick until it can step the sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      tick_r <= tick_in;
    end
  end

  // Step logic for one tick
  pths_step u_step (
    .cfg    (cfg_r),
    .st     (state_r),
    .tick   (tick_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // Sequence state: advance only when the tick's result is captured
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.stage        <= ST_IDLE;
      state_r.mark_time    <= '0;
      state_r.last_encoder <= '0;
      state_r.stall_count  <= '0;
      state_r.slew_flag    <= 1'b1;
      state_r.bounds_flag  <= 1'b0;
      state_r.done_flag    <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0,
                       res_r.finished,
                       res_r.stage_now,
                       res_r.homed,
                       res_r.bounds_on,
                       res_r.slew_on,
                       res_r.pan_encoder_taken,
                       res_r.pan_pwm_cmd,
                       res_r.pan_pwm_write,
                       res_r.tilt_pwm_cmd,
                       res_r.tilt_pwm_write};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The finish tick always leaves the head homed, bounded and idle
  a_finish_homed : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.finished |->
      res_r.homed && res_r.bounds_on && res_r.slew_on && res_r.stage_now == ST_IDLE)
    else $error("finish pulse without homed idle status");

  // A command value without its write flag must read as zero
  a_cmd_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (res_r.tilt_pwm_write || res_r.tilt_pwm_cmd == 8'sd0) &&
      (res_r.pan_pwm_write || res_r.pan_pwm_cmd == 8'sd0))
    else $error("PWM command value without write flag");

  // A stalled result must freeze the sequence state
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(state_r))
    else $error("sequence state moved while result was stalled");

endmodule

/* tb/pths_tb_pkg.sv */
// ----------------------------------------------------------------------------
// pths_tb_pkg: homing sequencer scoreboard
// Holds a cycle-free model of the sequencer: its registers, its stage and
// timers, and the queue of results that the accepted ticks call for.
// ----------------------------------------------------------------------------
package pths_tb_pkg;
  import pths_pkg::*;

  class homing_scoreboard;
    cfg_t        regs;
    seq_state_t  st;
    result_t     pending_results[$];
    int unsigned ticks_noted;
    int unsigned results_checked;
    int unsigned mismatch_count;
    int unsigned homing_runs;

    function new();
      regs.stall_sample_period_ms = RST_STALL_PERIOD;
      regs.pan_seek_stop_pwm      = RST_PAN_STOP_PWM;
      regs.pan_seek_hall_pwm      = RST_PAN_HALL_PWM;
      regs.tilt_seek_hall_pwm     = RST_TILT_HALL_PWM;
      regs.tilt_finetune_pwm      = RST_TILT_FINE_PWM;
      regs.finetune_time_ms       = RST_FINETUNE_TIME;
      regs.stall_repeat_count     = RST_STALL_REPEAT;
      st.stage        = ST_IDLE;
      st.mark_time    = '0;
      st.last_encoder = '0;
      st.stall_count  = '0;
      st.slew_flag    = 1'b1;
      st.bounds_flag  = 1'b0;
      st.done_flag    = 1'b0;
      ticks_noted     = 0;
      results_checked = 0;
      mismatch_count  = 0;
      homing_runs     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_STALL_PERIOD:  regs.stall_sample_period_ms = data;
        REG_PAN_STOP_PWM:  regs.pan_seek_stop_pwm      = data[7:0];
        REG_PAN_HALL_PWM:  regs.pan_seek_hall_pwm      = data[7:0];
        REG_TILT_HALL_PWM: regs.tilt_seek_hall_pwm     = data[7:0];
        REG_TILT_FINE_PWM: regs.tilt_finetune_pwm      = data[7:0];
        REG_FINETUNE_TIME: regs.finetune_time_ms       = data;
        REG_STALL_REPEAT:  regs.stall_repeat_count     = data[3:0];
        default: ;
      endcase
    endfunction

    // One control tick through the sequencer; returns the command/status word.
    function result_t advance_sequencer(tick_t tk);
      result_t              r;
      logic [TIME_BITS-1:0] since_mark;
      r = '0;
      since_mark = tk.now_ms - st.mark_time;
      if (tk.restart) begin
        st.stage       = ST_STOP;
        st.bounds_flag = 1'b0;
      end
      case (st.stage)
        ST_STOP: begin
          r.tilt_pwm_write = 1'b1;
          r.pan_pwm_write  = 1'b1;
          if (tk.tilt_pwm_now == 0 && tk.pan_pwm_now == 0) begin
            st.done_flag    = 1'b0;
            st.last_encoder = '0;
            st.slew_flag    = 1'b0;
            st.bounds_flag  = 1'b0;
            st.stage        = ST_PAN_INIT;
          end
        end
        ST_PAN_INIT: begin
          r.pan_pwm_write     = 1'b1;
          r.pan_pwm_cmd       = regs.pan_seek_stop_pwm;
          r.pan_encoder_taken = 1'b1;
          st.last_encoder     = tk.pan_encoder;
          st.stall_count      = '0;
          st.stage            = ST_PAN_SEEK_STOP;
        end
        ST_PAN_SEEK_STOP: begin
          if (since_mark >= regs.stall_sample_period_ms) begin
            st.mark_time        = tk.now_ms;
            r.pan_encoder_taken = 1'b1;
            if (tk.pan_encoder != st.last_encoder) begin
              st.last_encoder = tk.pan_encoder;
              st.stall_count  = '0;
            end else begin
              st.stall_count = st.stall_count + 4'd1;
              if (st.stall_count >= regs.stall_repeat_count) begin
                r.pan_pwm_write = 1'b1;
                r.pan_pwm_cmd   = regs.pan_seek_hall_pwm;
                st.stage        = ST_PAN_SEEK_HALL;
              end
            end
          end
        end
        ST_PAN_SEEK_HALL: begin
          if (tk.pan_hall) begin
            r.pan_pwm_write = 1'b1;
            st.stage        = ST_TILT_INIT;
          end
        end
        ST_TILT_INIT: begin
          r.tilt_pwm_write = 1'b1;
          r.tilt_pwm_cmd   = regs.tilt_seek_hall_pwm;
          st.stage         = ST_TILT_SEEK_HALL;
        end
        ST_TILT_SEEK_HALL: begin
          if (tk.tilt_hall) begin
            st.slew_flag     = 1'b1;
            r.tilt_pwm_write = 1'b1;
            r.tilt_pwm_cmd   = regs.tilt_finetune_pwm;
            st.mark_time     = tk.now_ms;
            st.stage         = ST_TILT_FINETUNE;
          end
        end
        ST_TILT_FINETUNE: begin
          if (since_mark >= regs.finetune_time_ms) begin
            st.slew_flag     = 1'b0;
            r.tilt_pwm_write = 1'b1;
            st.stage         = ST_FINISH;
          end
        end
        ST_FINISH: begin
          r.finished     = 1'b1;
          st.slew_flag   = 1'b1;
          st.bounds_flag = 1'b1;
          st.done_flag   = 1'b1;
          st.stage       = ST_IDLE;
        end
        default: st.stage = ST_IDLE;
      endcase
      r.slew_on   = st.slew_flag;
      r.bounds_on = st.bounds_flag;
      r.homed     = st.done_flag;
      r.stage_now = st.stage;
      return r;
    endfunction

    function void note_tick(tick_t tk);
      result_t r;
      r = advance_sequencer(tk);
      if (r.finished) homing_runs++;
      pending_results.push_back(r);
      ticks_noted++;
    endfunction

    function string field_diff(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) return $sformatf(" %s exp %0h act %0h", name, want, got);
      return "";
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      result_t got;
      result_t want;
      string   diffs;
      got.tilt_pwm_write    = d[0];
      got.tilt_pwm_cmd      = d[8:1];
      got.pan_pwm_write     = d[9];
      got.pan_pwm_cmd       = d[17:10];
      got.pan_encoder_taken = d[18];
      got.slew_on           = d[19];
      got.bounds_on         = d[20];
      got.homed             = d[21];
      got.stage_now         = d[25:22];
      got.finished          = d[26];
      results_checked++;
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected result %h with none pending", d);
        mismatch_count++;
        return;
      end
      want  = pending_results.pop_front();
      diffs = {field_diff("tilt_pwm_write", want.tilt_pwm_write, got.tilt_pwm_write),
               field_diff("tilt_pwm_cmd", want.tilt_pwm_cmd, got.tilt_pwm_cmd),
               field_diff("pan_pwm_write", want.pan_pwm_write, got.pan_pwm_write),
               field_diff("pan_pwm_cmd", want.pan_pwm_cmd, got.pan_pwm_cmd),
               field_diff("pan_encoder_taken", want.pan_encoder_taken, got.pan_encoder_taken),
               field_diff("slew_on", want.slew_on, got.slew_on),
               field_diff("bounds_on", want.bounds_on, got.bounds_on),
               field_diff("homed", want.homed, got.homed),
               field_diff("stage_now", want.stage_now, got.stage_now),
               field_diff("finished", want.finished, got.finished)};
      if (diffs != "") begin
        if (mismatch_count < 10) $display("result %0d mismatch:%s", results_checked, diffs);
        mismatch_count++;
      end
    endfunction
  endclass

endpackage

/* tb/tb_pan_tilt_homing_sequencer_core.sv */
// ----------------------------------------------------------------------------
// tb_pan_tilt_homing_sequencer_core: self-checking bench of the homing core
// Walks a directed homing run, then plays homing sequences with random
// timing, encoder travel and hall events under several register settings,
// with random stalls on both streams, and checks every result transfer
// against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_pan_tilt_homing_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pths_pkg::*;
  import pths_tb_pkg::*;

  localparam int HOLD_CYCLES = 400;        // long receiver hold-off
  localparam int PHASE_TICKS = 200;        // random ticks per register setting
  localparam int LIMIT_NS    = 8_000_000;  // far beyond the slowest clean run

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  // restart[0], now_ms[32:1], pan_encoder[48:33], tilt_pwm_now[56:49],
  // pan_pwm_now[64:57], tilt_hall[65], pan_hall[66], zeros above
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // tilt_pwm_write[0], tilt_pwm_cmd[8:1], pan_pwm_write[9], pan_pwm_cmd[17:10],
  // pan_encoder_taken[18], slew_on[19], bounds_on[20], homed[21],
  // stage_now[25:22], finished[26], zeros above
  logic [OUT_TDATA_W-1:0] out_tdata;

  homing_scoreboard sb = new();

  // Stimulus state: the millisecond clock and a crude pan mechanism
  logic [31:0]        clock_ms;
  logic signed [15:0] plant_enc;
  int                 travel_left;
  int                 tx_calm;
  int                 rx_calm;
  int                 settings_used;
  bit                 hold_req;

  pan_tilt_homing_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly back-to-back or short gaps, now and then a long one, and from
  // time to time a calm stretch with no gaps at all.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [7:0] rand_pwm();
    int v;
    v = int'($urandom_range(0, 254)) - 127;
    return v[7:0];
  endfunction

  function automatic tick_t mk_tick(bit rs, logic [31:0] now, logic signed [15:0] enc,
                                    int tilt_now, int pan_now, bit th, bit ph);
    tick_t tk;
    tk.restart      = rs;
    tk.now_ms       = now;
    tk.pan_encoder  = enc;
    tk.tilt_pwm_now = tilt_now[7:0];
    tk.pan_pwm_now  = pan_now[7:0];
    tk.tilt_hall    = th;
    tk.pan_hall     = ph;
    return tk;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_tick(tick_t tk);
    return {5'd0, tk.pan_hall, tk.tilt_hall, tk.pan_pwm_now, tk.tilt_pwm_now,
            tk.pan_encoder, tk.now_ms, tk.restart};
  endfunction

  function automatic cfg_t make_cfg(int period, int stop_pwm, int hall_pwm, int tilt_pwm,
                                    int fine_pwm, int fine_ms, int repeats);
    cfg_t c;
    c.stall_sample_period_ms = period[15:0];
    c.pan_seek_stop_pwm      = stop_pwm[7:0];
    c.pan_seek_hall_pwm      = hall_pwm[7:0];
    c.tilt_seek_hall_pwm     = tilt_pwm[7:0];
    c.tilt_finetune_pwm      = fine_pwm[7:0];
    c.finetune_time_ms       = fine_ms[15:0];
    c.stall_repeat_count     = repeats[3:0];
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    return make_cfg($urandom_range(1, 2000), rand_pwm(), rand_pwm(), rand_pwm(),
                    rand_pwm(), $urandom_range(0, 3000), $urandom_range(1, 15));
  endfunction

  // Build the next tick from the stage the sequencer is in, so that most
  // ticks push a homing run forward: motors settle in the stop stage, the
  // encoder travels for a while and then sits on the end stop, halls fire
  // at random, and time steps are scaled to the running intervals.
  function automatic tick_t next_tick();
    tick_t      tk;
    int         span;
    logic [3:0] stage;
    bit         noise;
    stage = sb.st.stage;
    noise = ($urandom_range(0, 9) == 0);
    case (stage)
      ST_PAN_SEEK_STOP: span = int'(sb.regs.stall_sample_period_ms) * 2 / 3 + 1;
      ST_TILT_FINETUNE: span = int'(sb.regs.finetune_time_ms) / 3 + 1;
      default:          span = 40;
    endcase
    if ($urandom_range(0, 15) == 0) clock_ms = clock_ms + $urandom;
    else clock_ms = clock_ms + $urandom_range(0, span);
    tk.now_ms  = clock_ms;
    tk.restart = (stage == ST_IDLE) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 99) == 0);
    if (tk.restart) stage = ST_STOP;
    if (stage == ST_PAN_INIT) travel_left = int'($urandom_range(0, 8));
    if (stage == ST_PAN_SEEK_STOP && travel_left > 0) begin
      plant_enc = plant_enc + 16'($urandom_range(1, 200));
      travel_left--;
    end else if ($urandom_range(0, 39) == 0) begin
      plant_enc = 16'($urandom_range(0, 65535));
    end
    tk.pan_encoder = plant_enc;
    if (stage == ST_STOP && $urandom_range(0, 1) == 0) begin
      tk.tilt_pwm_now = '0;
      tk.pan_pwm_now  = '0;
    end else begin
      tk.tilt_pwm_now = rand_pwm();
      tk.pan_pwm_now  = rand_pwm();
    end
    tk.tilt_hall = ($urandom_range(0, 3) == 0);
    tk.pan_hall  = ($urandom_range(0, 3) == 0);
    // Scramble a few ticks outright to catch whatever a tidy run misses
    if (noise) begin
      tk.restart      = ($urandom_range(0, 7) == 0);
      tk.pan_encoder  = 16'($urandom_range(0, 65535));
      tk.tilt_pwm_now = rand_pwm();
      tk.pan_pwm_now  = rand_pwm();
    end
    return tk;
  endfunction

  // Offer one tick after a random gap and hold it until the transfer.
  task automatic send_tick(input tick_t tk);
    int gap;
    gap = pick_gap(tx_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = pack_tick(tk);
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(tk);
  endtask

  task automatic run_random(input int n);
    int i;
    for (i = 0; i < n; i++) send_tick(next_tick());
  endtask

  // Drop valid and wait for every outstanding result, plus pipeline slack.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Signed registers go out sign-extended; the core keeps the low byte.
  task automatic apply_settings(input cfg_t c);
    write_reg(REG_STALL_PERIOD, c.stall_sample_period_ms);
    write_reg(REG_PAN_STOP_PWM, {{8{c.pan_seek_stop_pwm[7]}}, c.pan_seek_stop_pwm});
    write_reg(REG_PAN_HALL_PWM, {{8{c.pan_seek_hall_pwm[7]}}, c.pan_seek_hall_pwm});
    write_reg(REG_TILT_HALL_PWM, {{8{c.tilt_seek_hall_pwm[7]}}, c.tilt_seek_hall_pwm});
    write_reg(REG_TILT_FINE_PWM, {{8{c.tilt_finetune_pwm[7]}}, c.tilt_finetune_pwm});
    write_reg(REG_FINETUNE_TIME, c.finetune_time_ms);
    write_reg(REG_STALL_REPEAT, {12'd0, c.stall_repeat_count});
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input cfg_t c);
    drain_results();
    apply_settings(c);
    run_random(PHASE_TICKS);
  endtask

  // Receiver: random stalls, plus one long hold-off on request so that the
  // core backs up and stalls its input while ticks keep being offered.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        stall_left = pick_gap(rx_calm);
      end
    end
  end

  // Check each result transfer as it happens.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout: %0d results still outstanding", sb.pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [31:0] t;
    int          k;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    hold_req      = 1'b0;
    plant_enc     = '0;
    travel_left   = 0;
    tx_calm       = 0;
    rx_calm       = 0;
    settings_used = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed homing run on the default registers.
    // Idle ignores a tick without restart.
    send_tick(mk_tick(0, 32'h0, 16'sh0, 0, 0, 0, 0));
    // Restart with both motors running, then hold in stop until both are zero.
    send_tick(mk_tick(1, 32'hFFFF_FFFF, -16'sd32768, -127, 127, 1, 1));
    send_tick(mk_tick(0, 32'hFFFF_FFF0, 16'sd32767, 127, -127, 0, 0));
    send_tick(mk_tick(0, 32'hFFFF_FF00, 16'sh0, 0, 5, 0, 0));
    send_tick(mk_tick(0, 32'hFFFF_FF00, 16'sh0, 0, 0, 0, 0));
    // Pan init latches the encoder; the first sample follows at once.
    send_tick(mk_tick(0, 32'hFFFF_FF00, 16'sd32767, -127, 127, 0, 0));
    send_tick(mk_tick(0, 32'hFFFF_FF10, 16'sd32767, 0, 0, 0, 0));
    send_tick(mk_tick(0, 32'hFFFF_FF20, 16'sd32767, 0, 0, 0, 0));
    // Exactly one period later, across the wrap of the ms clock.
    send_tick(mk_tick(0, 32'h0000_003C, 16'sd32767, 0, 0, 0, 0));
    // Encoder moves: count restarts, then four still samples declare the stall.
    t = 32'h0000_0168;
    send_tick(mk_tick(0, t, -16'sd32768, 0, 0, 0, 0));
    for (k = 0; k < 4; k++) begin
      t = t + 32'd300;
      send_tick(mk_tick(0, t, -16'sd32768, 0, 0, 1, 0));
    end
    // Pan hall, tilt init, tilt hall.
    send_tick(mk_tick(0, t, 16'sh0, 0, 0, 1, 0));
    send_tick(mk_tick(0, t, 16'sh0, 0, 0, 0, 1));
    send_tick(mk_tick(0, t, 16'sh0, 0, 0, 1, 1));
    send_tick(mk_tick(0, t, 16'sh0, 0, 0, 0, 1));
    send_tick(mk_tick(0, t, 16'sh0, 0, 0, 1, 0));
    // Finetune ends on the exact boundary, then finish and back to idle.
    send_tick(mk_tick(0, t + 32'd1299, 16'sh0, 0, 0, 0, 0));
    send_tick(mk_tick(0, t + 32'd1300, 16'sh0, 0, 0, 0, 0));
    send_tick(mk_tick(0, t + 32'd1301, 16'sh0, 0, 0, 0, 0));
    send_tick(mk_tick(0, t + 32'd1302, 16'sh0, 0, 0, 0, 0));
    clock_ms = t + 32'd1302;

    // Default registers, with the long receiver hold-off on top.
    hold_req = 1'b1;
    run_random(PHASE_TICKS);
    // Zero period and finetune, zero repeat count, -128 passed through.
    run_phase(make_cfg(0, -128, 127, -127, 0, 0, 0));
    // Upper extremes.
    run_phase(make_cfg(65535, 127, -127, 127, -128, 65535, 15));
    // Smallest useful values.
    run_phase(make_cfg(1, 0, -1, 1, 127, 1, 1));
    run_phase(random_cfg());
    run_phase(random_cfg());

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d control ticks under %0d register settings, %0d full homing runs.",
             sb.ticks_noted, settings_used, sb.homing_runs);
    $display("Compared %0d results, %0d mismatching.", sb.results_checked, sb.mismatch_count);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
